FILE: sv/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg: shared types and constants for the sorted set core
// Field widths, request codes, controller states and the command/status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int VAL_W     = 32;  // width of a stored value
  localparam int POS_OUT_W = 4;   // width of the position result field
  localparam int CNT_OUT_W = 5;   // width of the count result field

  // request codes
  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_UPD  = 2'b10
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic cap;  // take the request and register the row compare
    logic upd;  // apply the update and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_hold;  // result register full and the receiver is stalling
  } sts_t;

endpackage

FILE: sv/ssi_ctrl.sv
// ----------------------------------------------------------------------------
// ssi_ctrl: request sequencer for the sorted set core
// Two-state machine: take a request and compare, then update and present.
// ----------------------------------------------------------------------------
module ssi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output ssi_pkg::cmd_t cmd,
  input  ssi_pkg::sts_t sts
);
  import ssi_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap   = 1'b1;
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        // wait while the previous result is still held by the receiver
        if (!sts.out_hold) begin
          cmd.upd   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_upd_follows_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cap |=> (state_r == S_UPD))
    else $error("capture not followed by update state");

  a_no_cap_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> !cmd.cap)
    else $error("request captured while stalled");

  a_upd_releases: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |=> !in_stall)
    else $error("input not released after update");
`endif

endmodule

FILE: sv/ssi_datapath.sv
// ----------------------------------------------------------------------------
// ssi_datapath: register row, parallel compare and shift-insert
// Each cell compares its own entry with the key; the boundary of the
// less-than thermometer gives the sorted position. Result register on exit.
// ----------------------------------------------------------------------------
module ssi_datapath #(
  parameter int CAPACITY = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_req_type,
  input  logic signed [ssi_pkg::VAL_W-1:0]    in_value,
  input  ssi_pkg::cmd_t                       cmd,
  output ssi_pkg::sts_t                       sts,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_hit,
  output logic                                out_inserted,
  output logic                                out_overflow,
  output logic [ssi_pkg::POS_OUT_W-1:0]       out_position,
  output logic [ssi_pkg::CNT_OUT_W-1:0]       out_count,
  output logic                                out_empty_res
);
  import ssi_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic signed [VAL_W-1:0] entries_r   [CAPACITY];
  logic signed [VAL_W-1:0] entries_nxt [CAPACITY];
  logic [CNT_W-1:0]        count_r, count_nxt;

  logic                    req_r;
  logic signed [VAL_W-1:0] key_r;
  logic [CAPACITY-1:0]     lt_r, lt_nxt;
  logic [CAPACITY-1:0]     eq_r, eq_nxt;
  logic [CAPACITY-1:0]     hot;

  logic [IDX_W-1:0]        at;
  logic [IDX_W-1:0]        pos;
  logic                    found, full, do_ins;

  logic                    out_valid_r;
  logic                    out_hit_r, out_inserted_r, out_overflow_r, out_empty_r;
  logic [POS_OUT_W-1:0]    out_position_r;
  logic [CNT_OUT_W-1:0]    out_count_r;

  // per-cell compare against the incoming value; invalid cells never match
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt_nxt[i] = (CNT_W'(i) < count_r) && (entries_r[i] < in_value);
      eq_nxt[i] = (CNT_W'(i) < count_r) && (entries_r[i] == in_value);
    end
  end

  // thermometer boundary -> one-hot insert point -> encoded index
  always_comb begin
    hot[0] = !lt_r[0];
    for (int i = 1; i < CAPACITY; i++) begin
      hot[i] = !lt_r[i] && lt_r[i-1];
    end
    at = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hot[i]) begin
        at = at | IDX_W'(i);
      end
    end
  end

  assign found  = |eq_r;
  assign full   = (count_r == CNT_W'(CAPACITY));
  assign do_ins = (req_r == REQ_INSERT) && !found && !full;
  assign pos    = (found || do_ins) ? at : '0;

  assign count_nxt = count_r + CNT_W'(do_ins);

  // shift-insert: below the point keep, at the point the key, above it move up
  always_comb begin
    entries_nxt[0] = lt_r[0] ? entries_r[0] : key_r;
    for (int i = 1; i < CAPACITY; i++) begin
      if (lt_r[i]) begin
        entries_nxt[i] = entries_r[i];
      end else if (hot[i]) begin
        entries_nxt[i] = key_r;
      end else begin
        entries_nxt[i] = entries_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      key_r <= in_value;
      lt_r  <= lt_nxt;
      eq_r  <= eq_nxt;
    end
    if (cmd.upd && do_ins) begin
      for (int i = 0; i < CAPACITY; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
    if (cmd.upd) begin
      out_hit_r      <= found;
      out_inserted_r <= do_ins;
      out_overflow_r <= (req_r == REQ_INSERT) && !found && full;
      out_position_r <= POS_OUT_W'(pos);
      out_count_r    <= CNT_OUT_W'(count_nxt);
      out_empty_r    <= (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.upd) begin
        count_r <= count_nxt;
      end
      if (cmd.upd) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.out_hold   = out_valid_r && out_stall;

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_inserted   = out_inserted_r;
  assign out_overflow   = out_overflow_r;
  assign out_position   = out_position_r;
  assign out_count      = out_count_r;
  assign out_empty_res  = out_empty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd && do_ins) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("count not advanced on insert");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_hit_r, out_inserted_r, out_overflow_r}))
    else $error("result flags not exclusive");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    sts.out_hold |-> !cmd.upd)
    else $error("held result overwritten");
`endif

endmodule

FILE: sv/sorted_set_insert_lookup_core.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_lookup_core: sorted set of signed 32-bit values
// Keeps an ascending, duplicate-free table of up to CAPACITY values with
// insert and lookup requests; one result beat per request beat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_*): a beat carries a request type (insert or query)
//   and a signed value; taken when in_valid is high and in_stall is low.
//   Result channel (out_*): one beat per request with hit, inserted and
//   overflow flags, position, count after the request and an empty flag.
//   A request is registered with its row compare; the update then
//   loads the result register, which presents the result beat.
//   The next request is taken only after that update, since the compare
//   over the register row is followed by the shift-insert and the next
//   request must see the updated table.
//   The result sits in an output register, so a stalled receiver does not
//   block the next request beat; it only holds the update cycle, and the
//   input with it, while an earlier result is still waiting.
//   Reset (rst_n low, synchronous) empties the table and drops any
//   pending result; entry contents are not cleared.
//   An insert into a full table is refused and flagged as overflow.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup_core #(
  parameter int CAPACITY = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic signed [ssi_pkg::VAL_W-1:0]  in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic                              out_inserted,
  output logic                              out_overflow,
  output logic [ssi_pkg::POS_OUT_W-1:0]     out_position,
  output logic [ssi_pkg::CNT_OUT_W-1:0]     out_count,
  output logic                              out_empty_res
);
  import ssi_pkg::*;

  cmd_t cmd;  // sequencer commands
  sts_t sts;  // datapath status

  // sequencer: idle/accept, then update once the result slot is free
  ssi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // table row, compare, shift-insert and result register
  ssi_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_req_type   (in_req_type),
    .in_value      (in_value),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_hit       (out_hit),
    .out_inserted  (out_inserted),
    .out_overflow  (out_overflow),
    .out_position  (out_position),
    .out_count     (out_count),
    .out_empty_res (out_empty_res)
  );

`ifndef SYNTHESIS
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second request taken before update");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && !out_valid) |=> ##1 out_valid)
    else $error("result beat missing after request");

  a_empty_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == '0)) || (CAPACITY > 31))
    else $error("empty flag disagrees with count");
`endif

endmodule

FILE: bench/sorted_set_insert_lookup_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_set_insert_lookup_core_tb: self-checking bench for the sorted set core
// Drives insert and query beats with bursty valid and a patterned result
// stall. A local copy of the table predicts each result beat, which is
// checked field by field in order. Directed beats cover the empty table,
// value extremes, duplicates, mid-table shifts and overflow; random beats
// then hammer the full table with hits, misses and refused inserts.
// ----------------------------------------------------------------------------
module sorted_set_insert_lookup_core_tb;

  import ssi_pkg::*;

  localparam int SET_CAP        = 16;    // matches the instance parameter
  localparam int RANDOM_BEATS   = 1525;  // roughly 1550 beats with directed
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side
  localparam int DRAIN_CYCLES   = 8;     // quiet cycles watched for stray result beats

  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  // receiver stall patterns, rotated at random
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_COMB
  } stall_mode_t;

  typedef struct packed {
    logic                 hit;
    logic                 inserted;
    logic                 overflow;
    logic [POS_OUT_W-1:0] position;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty_res;
  } set_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = REQ_INSERT;
  logic signed [VAL_W-1:0] in_value    = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic                    out_hit;
  logic                    out_inserted;
  logic                    out_overflow;
  logic [POS_OUT_W-1:0]    out_position;
  logic [CNT_OUT_W-1:0]    out_count;
  logic                    out_empty_res;

  // shadow table: ascending, distinct, first set_cnt slots valid
  logic signed [VAL_W-1:0] set_vals [SET_CAP];
  int                      set_cnt = 0;

  set_result_t pending_results[$];  // predicted beats, oldest first

  int errors    = 0;
  int n_checked = 0;
  int n_hit     = 0;
  int n_ins     = 0;
  int n_ovf     = 0;
  int n_miss    = 0;

  // sender burst shaping
  int burst_left = 0;

  // receiver stall shaping
  stall_mode_t stall_mode = STALL_NONE;
  int          mode_left  = 0;
  int          comb_phase = 0;

  int idle_cycles = 0;

  sorted_set_insert_lookup_core #(
    .CAPACITY(SET_CAP)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_hit      (out_hit),
    .out_inserted (out_inserted),
    .out_overflow (out_overflow),
    .out_position (out_position),
    .out_count    (out_count),
    .out_empty_res(out_empty_res)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor: lower-bound search over the shadow table, then either report a
  // hit, refuse on a full table, shift the upper part up and slot in, or miss.
  // Updates the shadow state, so call once per accepted request beat.
  // --------------------------------------------------------------------------
  function automatic set_result_t apply_request(logic rt, logic signed [VAL_W-1:0] v);
    set_result_t r;
    int          at;
    bit          found;
    r     = '0;
    at    = set_cnt;
    found = 1'b0;
    for (int i = 0; i < set_cnt; i++) begin
      if (at == set_cnt && set_vals[i] >= v) begin
        at    = i;
        found = (set_vals[i] == v);
      end
    end
    if (found) begin
      r.hit      = 1'b1;
      r.position = POS_OUT_W'(at);
    end else if (rt == REQ_INSERT) begin
      if (set_cnt >= SET_CAP) begin
        r.overflow = 1'b1;
      end else begin
        for (int i = set_cnt; i > at; i--) set_vals[i] = set_vals[i-1];
        set_vals[at] = v;
        set_cnt++;
        r.inserted = 1'b1;
        r.position = POS_OUT_W'(at);
      end
    end
    r.count     = CNT_OUT_W'(set_cnt);
    r.empty_res = (set_cnt == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: present one request beat, hold it until taken, predict on the
  // accepting edge. Valid is dropped only between bursts, so it never gets
  // two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic rt, input logic signed [VAL_W-1:0] v);
    int          gap;
    set_result_t pred;
    in_valid    <= 1'b1;
    in_req_type <= rt;
    in_value    <= v;
    do @(posedge clk); while (in_stall);
    pred            = apply_request(rt, v);
    pending_results = {pending_results, pred};
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // new burst; a quarter of them run long with no gap in front
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(20, 60);
      end else begin
        burst_left = $urandom_range(0, 12);
        gap        = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver stall: pattern changes at random intervals - none, light,
  // heavy random, or a fixed one-in-three comb.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(20, 120);
    end else begin
      mode_left <= mode_left - 1;
    end
    comb_phase <= (comb_phase == 2) ? 0 : comb_phase + 1;
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (comb_phase == 0);
    endcase
  end

  // --------------------------------------------------------------------------
  // Result checker: each beat taken is matched against the oldest prediction.
  // --------------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    set_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual count %0d",
                 $time, out_count);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit",       exp_r.hit,       out_hit);
        check_field("inserted",  exp_r.inserted,  out_inserted);
        check_field("overflow",  exp_r.overflow,  out_overflow);
        check_field("position",  exp_r.position,  out_position);
        check_field("count",     exp_r.count,     out_count);
        check_field("empty_res", exp_r.empty_res, out_empty_res);
        n_checked++;
        if (exp_r.hit)           n_hit++;
        else if (exp_r.inserted) n_ins++;
        else if (exp_r.overflow) n_ovf++;
        else                     n_miss++;
      end
    end
  end

  // watchdog: a stuck handshake on either side ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // lookups on a table that has never held anything
  task automatic test_empty_queries();
    send_request(REQ_QUERY, '0);
    send_request(REQ_QUERY, VAL_MIN);
    send_request(REQ_QUERY, VAL_MAX);
  endtask

  // both ends of the signed range, sign boundary, duplicate insert, miss
  task automatic test_extremes();
    send_request(REQ_INSERT, '0);
    send_request(REQ_INSERT, VAL_MAX);
    send_request(REQ_INSERT, VAL_MIN);
    send_request(REQ_INSERT, -1);
    send_request(REQ_INSERT, 1);
    send_request(REQ_INSERT, VAL_MIN);  // already present: hit, no change
    send_request(REQ_QUERY,  VAL_MAX);
    send_request(REQ_QUERY,  5);        // absent: miss, position zero
  endtask

  // fill to capacity with mid-table inserts, then a refused insert and
  // a duplicate insert on the full table
  task automatic test_fill_overflow();
    logic signed [VAL_W-1:0] fill_vals [11];
    fill_vals = '{1000, 500, -500, 2000, VAL_MIN + 1, VAL_MAX - 1,
                  250, -250, 750, 100, -100};
    foreach (fill_vals[i]) send_request(REQ_INSERT, fill_vals[i]);
    send_request(REQ_INSERT, 7);    // full: overflow
    send_request(REQ_INSERT, 250);  // full but present: hit
    send_request(REQ_QUERY,  -1);
  endtask

  // mostly present values and their neighbours, some wide random values
  function automatic logic signed [VAL_W-1:0] draw_value();
    logic signed [VAL_W-1:0] v;
    v = $urandom;
    if (set_cnt > 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: v = set_vals[$urandom_range(0, set_cnt - 1)];
        3:       v = set_vals[$urandom_range(0, set_cnt - 1)] + 1;
        4:       v = set_vals[$urandom_range(0, set_cnt - 1)] - 1;
        5:       v = ($urandom_range(0, 1) != 0) ? VAL_MIN : VAL_MAX;
        default: ;
      endcase
    end
    return v;
  endfunction

  task automatic test_random_mix(input int n_beats);
    for (int i = 0; i < n_beats; i++) begin
      send_request(($urandom_range(0, 1) != 0) ? REQ_QUERY : REQ_INSERT, draw_value());
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_queries();
    test_extremes();
    test_fill_overflow();
    test_random_mix(RANDOM_BEATS);

    // drain, then watch for stray result beats
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result beats: %0d hits, %0d inserts, %0d overflows, %0d misses.",
             n_checked, n_hit, n_ins, n_ovf, n_miss);
    $display("Empty-table lookups, signed extremes, shifting fill and full-table traffic.");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/ssi_pkg.sv
sv/ssi_ctrl.sv
sv/ssi_datapath.sv
sv/sorted_set_insert_lookup_core.sv
bench/sorted_set_insert_lookup_core_tb.sv
